@@ hdl/llhf_pkg.sv @@
`default_nettype none

package llhf_pkg;

	localparam int WINDOW_DEPTH_DEF = 3;
	localparam int SAMPLE_BITS_DEF  = 10;
	localparam int SAMPLE_MAX_BITS  = 16;
	localparam int LEVEL_BITS       = 3;
	localparam int LEVEL_COUNT      = 8;

	typedef logic [LEVEL_BITS-1:0]      level_t;
	typedef logic [SAMPLE_MAX_BITS-1:0] wide_sample_t;

	localparam level_t LEVEL_BOTTOM = level_t'(0);
	localparam level_t LEVEL_TOP    = level_t'(LEVEL_COUNT - 1);

	localparam wide_sample_t BOUND_LOW [LEVEL_COUNT] = '{
		16'd0, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128, 16'd256, 16'd512
	};

	localparam wide_sample_t BOUND_HIGH [LEVEL_COUNT] = '{
		16'd12, 16'd23, 16'd46, 16'd91, 16'd182, 16'd363, 16'd725, 16'd1023
	};

	function automatic level_t propose_level(level_t level, wide_sample_t sample);
		level_t lv;
		lv = level;
		if ((sample < BOUND_LOW[lv]) && (lv != LEVEL_BOTTOM)) begin
			lv = lv - level_t'(1);
		end
		if ((sample > BOUND_HIGH[lv]) && (lv != LEVEL_TOP)) begin
			lv = lv + level_t'(1);
		end
		return lv;
	endfunction

endpackage

`default_nettype wire

@@ hdl/llhf_vote.sv @@
`default_nettype none

module llhf_vote import llhf_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  wire logic [WINDOW_DEPTH-1:0][SAMPLE_BITS-1:0] window,
	input  wire level_t                                   level,
	output level_t                                        level_next
);

	level_t                  proposal [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] match;

	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			proposal[i] = propose_level(level, SAMPLE_MAX_BITS'(window[i]));
			match[i]    = (proposal[i] == proposal[0]);
		end
		level_next = (&match) ? proposal[0] : level;
	end

endmodule

`default_nettype wire

@@ hdl/light_level_hysteresis_filter.sv @@
`default_nettype none

// Ambient-light brightness filter. Each accepted light_sample enters a ring of the
// last WINDOW_DEPTH samples (all zero after reset); every stored sample proposes a
// level one step around the current one against fixed per-level low/high bounds,
// and the level moves only when all proposals agree. One brightness_level item is
// returned per sample. The block takes one item per cycle unless out_ready holds back a
// waiting result: a sample is held in the input register, then the vote over the ring and
// the level update are registered into the level register, which drives the result
// directly. Input is still accepted while a result waits, until both registers are full.

module light_level_hysteresis_filter import llhf_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] light_sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [LEVEL_BITS-1:0]       brightness_level
);

	localparam int SLOT_BITS = $clog2(WINDOW_DEPTH);
	localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(WINDOW_DEPTH - 1);

	logic                                   valid_s1;
	logic [SAMPLE_BITS-1:0]                 sample_s1;
	logic [WINDOW_DEPTH-1:0][SAMPLE_BITS-1:0] window_q;
	logic [WINDOW_DEPTH-1:0][SAMPLE_BITS-1:0] window_next;
	logic [SLOT_BITS-1:0]                   slot_q;
	level_t                                 level_q;
	level_t                                 level_next;
	logic                                   out_valid_q;
	logic                                   advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		window_next = window_q;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (slot_q == SLOT_BITS'(i)) begin
				window_next[i] = sample_s1;
			end
		end
	end

	llhf_vote #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_vote (
		.window    (window_next),
		.level     (level_q),
		.level_next(level_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= light_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			slot_q      <= '0;
			level_q     <= LEVEL_BOTTOM;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				window_q <= window_next;
				slot_q   <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_BITS'(1);
				level_q  <= level_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign brightness_level = level_q;

endmodule

`default_nettype wire

@@ hdl/llhf_checker.sv @@
`default_nettype none

module llhf_checker import llhf_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [LEVEL_BITS-1:0] brightness_level
);

	level_t     last_level_q;
	logic [1:0] pending_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= LEVEL_BOTTOM;
			pending_q    <= '0;
		end else begin
			if (out_take) begin
				last_level_q <= brightness_level;
			end
			pending_q <= pending_q + 2'(in_take) - 2'(out_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(brightness_level))
		else $error("result item changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> (brightness_level == last_level_q)
			|| (brightness_level == last_level_q + level_t'(1))
			|| (brightness_level == last_level_q - level_t'(1)))
		else $error("brightness level moved by more than one step");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result item without an accepted sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && pending_q == 2'd2)
		else $error("input stalled while the block has room");

endmodule

bind light_level_hysteresis_filter llhf_checker u_llhf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.brightness_level(brightness_level)
);

`default_nettype wire

@@ dv/light_level_hysteresis_filter_test.sv @@
`timescale 1ns / 100ps

module light_level_hysteresis_filter_test;
	import llhf_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 9;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;
	localparam int REPORT_LIMIT   = 10;
	localparam int PREDICTED      = -1;
	localparam int PROBE_COUNT    = 25;
	localparam int RING_DEPTH     = WINDOW_DEPTH_DEF;
	localparam int SAMPLE_TOP     = (1 << SAMPLE_BITS_DEF) - 1;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [SAMPLE_BITS_DEF-1:0] light_sample;
	logic                       out_valid;
	logic                       out_ready;
	level_t                     brightness_level;

	int low_bound  [LEVEL_COUNT] = '{0, 8, 16, 32, 64, 128, 256, 512};
	int high_bound [LEVEL_COUNT] = '{12, 23, 46, 91, 182, 363, 725, 1023};

	// climb from the cleared ring to the top, fall back to the bottom, then probe a bound
	int probe_sample [PROBE_COUNT] = '{
		0,
		1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		12, 13, 13, 13
	};
	int probe_level [PROBE_COUNT] = '{
		0,
		0, 0, 1, 2, 3, 4, 5, 6, 7, 7,
		7, 7, 6, 5, 4, 3, 2, 1, 0, 0,
		PREDICTED, PREDICTED, PREDICTED, PREDICTED
	};

	int     ring_samples [RING_DEPTH] = '{default: 0};
	int     ring_slot     = 0;
	level_t tracked_level = LEVEL_BOTTOM;

	level_t     expected_levels [$];
	int         probe_expect;
	bit         calm          = 1'b0;
	int         fail_count    = 0;
	int         levels_checked = 0;
	int         items_sent    = 0;
	int         stall_cycles  = 0;
	logic [7:0] levels_seen   = '0;

	light_level_hysteresis_filter i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.light_sample     (light_sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.brightness_level (brightness_level)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic level_t vote_for(level_t level, int sample);
		int lv;
		lv = int'(level);
		if (sample < low_bound[lv] && lv > int'(LEVEL_BOTTOM)) lv--;
		if (sample > high_bound[lv] && lv < int'(LEVEL_TOP)) lv++;
		return level_t'(lv);
	endfunction

	function level_t advance_level(input int sample);
		level_t first;
		bit     agree;
		ring_samples[ring_slot] = sample;
		ring_slot = (ring_slot + 1) % RING_DEPTH;
		first = vote_for(tracked_level, ring_samples[0]);
		agree = 1'b1;
		for (int i = 1; i < RING_DEPTH; i++) begin
			if (vote_for(tracked_level, ring_samples[i]) != first) agree = 1'b0;
		end
		if (agree) tracked_level = first;
		return tracked_level;
	endfunction

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	function int sender_gap();
		if (calm) return 0;
		return ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
	endfunction

	function int near(int center, int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0) v = 0;
		if (v > SAMPLE_TOP) v = SAMPLE_TOP;
		return v;
	endfunction

	task offer_sample(input int value, input int typed_level, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		light_sample <= value[SAMPLE_BITS_DEF-1:0];
		probe_expect <= typed_level;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task drain_levels();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_levels.size() != 0);
	endtask

	always @(posedge clk) begin
		level_t predicted;
		level_t wanted;
		bit     moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				moved = 1'b1;
				predicted = advance_level(int'(light_sample));
				wanted = (probe_expect == PREDICTED) ? predicted : level_t'(probe_expect);
				expected_levels.push_back(wanted);
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				levels_seen[brightness_level] = 1'b1;
				if (expected_levels.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: brightness_level %0d arrived with nothing expected",
							$time, brightness_level);
				end else begin
					wanted = expected_levels.pop_front();
					levels_checked++;
					if (brightness_level !== wanted) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: brightness_level expected %0d, got %0d",
								$time, wanted, brightness_level);
					end
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
			end
		end
	end

	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no item moved for %0d cycles, %0d levels outstanding",
			WATCHDOG_LIMIT, expected_levels.size());
		$display("light_level_hysteresis_filter_test failed");
		$finish;
	end

	initial begin
		int  random_sent;
		int  mode;
		int  run_len;
		int  tier;
		int  anchor;
		int  spread;
		int  value;
		bit  drained_mid;
		random_sent  = 0;
		drained_mid  = 1'b0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		light_sample <= '0;
		probe_expect <= PREDICTED;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_COUNT; i++)
			offer_sample(probe_sample[i], probe_level[i], (i % 4 == 3) ? pick_gap() : 0);

		// hold until the table rows have all come back
		drain_levels();

		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) calm = ~calm;
			if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
				drain_levels();
				drained_mid = 1'b1;
			end
			mode    = $urandom_range(0, 99);
			run_len = $urandom_range(3, 6);
			tier    = $urandom_range(0, LEVEL_COUNT - 1);
			spread  = 0;
			if (mode < 55) begin
				anchor = $urandom_range(0, 1) ? low_bound[tier] : high_bound[tier];
				spread = 3;
			end else if (mode < 80) begin
				anchor = $urandom_range(0, SAMPLE_TOP);
			end else begin
				anchor  = $urandom_range(0, SAMPLE_TOP);
				run_len = 1;
			end
			for (int k = 0; k < run_len; k++) begin
				value = near(anchor, spread);
				if (mode < 80 && $urandom_range(0, 9) == 0)
					value = $urandom_range(0, SAMPLE_TOP);
				offer_sample(value, PREDICTED, sender_gap());
				random_sent++;
			end
		end

		drain_levels();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d light samples sent (%0d from the table), %0d levels compared",
			items_sent, PROBE_COUNT, levels_checked);
		$display("levels reached (bit per level): %b, %0d failures", levels_seen, fail_count);
		if (fail_count == 0 && expected_levels.size() == 0) begin
			$display("light_level_hysteresis_filter_test passed");
		end else begin
			$display("light_level_hysteresis_filter_test failed");
		end
		$finish;
	end

endmodule
